FILE: rtl/ile_pkg.sv
// shared types and constants for the indexed list engine
package ile_pkg;

   // default list depth and fixed field widths
   localparam int DEPTH_DEFAULT = 64;
   localparam int WORD_W        = 32;
   localparam int POS_W         = 7;
   localparam int COUNT_W       = 7;
   // index width carried to the cells, wide enough for any depth up to 1024
   localparam int CMD_IDX_W     = 11;

   typedef enum logic [2:0] {
      ACT_PUSH   = 3'd0,
      ACT_APPEND = 3'd1,
      ACT_POP    = 3'd2,
      ACT_GET    = 3'd3,
      ACT_PUT    = 3'd4,
      ACT_INSERT = 3'd5,
      ACT_DELETE = 3'd6,
      ACT_CLEAR  = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_SHIFT_UP   = 2'd1,
      CELL_SHIFT_DOWN = 2'd2,
      CELL_WRITE      = 2'd3
   } cell_op_type;

   typedef struct packed {
      action_type               action;
      logic [POS_W-1:0]         position;
      logic signed [WORD_W-1:0] value;
   } req_beat_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] read_value;
      logic [COUNT_W-1:0]       count;
      logic                     is_empty;
      status_type               status;
   } rsp_beat_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                     load;
      cell_op_type              op;
      logic [CMD_IDX_W-1:0]     idx;
      logic                     rd_en;
      logic [CMD_IDX_W-1:0]     rd_idx;
      logic signed [WORD_W-1:0] value;
   } cell_cmd_type;

endpackage

FILE: rtl/indexed_list_engine_top.sv
// top level of the indexed list engine: controller plus a chain of list cells
//
// usage:
//   req channel (req_valid, req_stall, req_data) carries one request beat:
//   action, 1-based position and value. rsp channel (rsp_valid, rsp_stall,
//   rsp_data) returns exactly one beat per request: read value, new length,
//   empty flag and status. failed requests leave the list unchanged.
//   a beat moves when valid is high and stall is low at a rising edge.
// pipeline:
//   every cell shifts or writes at the accept edge, and the selected cell's
//   read slice is registered at that edge too; the merged slice, new length
//   and status then go into the result register once it is free, and a new
//   request is taken only after the previous result has been registered.
// reset:
//   synchronous, active high; empties the list and drops any pending result.
//   cell words are not cleared, positions beyond the length are never read.
// stall:
//   while rsp_stall holds a result, the block stalls req after the next
//   request has been accepted into the cells.
module indexed_list_engine_top #(
   parameter int DEPTH = ile_pkg::DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ile_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ile_pkg::rsp_beat_type rsp_data
);

   ile_pkg::cell_cmd_type cmd;
   logic signed [ile_pkg::WORD_W-1:0] words  [DEPTH];
   logic signed [ile_pkg::WORD_W-1:0] slices [DEPTH];
   logic signed [ile_pkg::WORD_W-1:0] rd_word;

   ile_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .rd_word   (rd_word)
   );

   // chain of cells, each wired to its two neighbors
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [ile_pkg::WORD_W-1:0] left_word;
      logic signed [ile_pkg::WORD_W-1:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = cmd.value;
      end else begin : g_inner_l
         assign left_word = words[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_word = words[i];
      end else begin : g_inner_r
         assign right_word = words[i+1];
      end

      ile_cell #(
         .INDEX(i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (words[i]),
         .rd_slice   (slices[i])
      );
   end

   // at most one slice is nonzero, merge them
   always_comb begin
      rd_word = '0;
      for (int k = 0; k < DEPTH; k++) begin
         rd_word = rd_word | slices[k];
      end
   end

endmodule

FILE: rtl/ile_cell.sv
// one list slot: holds a word, shifts with its neighbors, offers a read slice
module ile_cell #(
   parameter int INDEX = 0
) (
   input  logic                             clock,
   input  ile_pkg::cell_cmd_type            cmd,
   input  logic signed [ile_pkg::WORD_W-1:0] left_word,
   input  logic signed [ile_pkg::WORD_W-1:0] right_word,
   output logic signed [ile_pkg::WORD_W-1:0] word,
   output logic signed [ile_pkg::WORD_W-1:0] rd_slice
);

   localparam logic [ile_pkg::CMD_IDX_W-1:0] MY_IDX = ile_pkg::CMD_IDX_W'(INDEX);

   logic signed [ile_pkg::WORD_W-1:0] word_ff, word_in;
   logic signed [ile_pkg::WORD_W-1:0] rd_ff, rd_in;

   // next word from the broadcast operation
   always_comb begin
      word_in = word_ff;
      case (cmd.op)
         ile_pkg::CELL_SHIFT_UP: begin
            if (MY_IDX > cmd.idx) begin
               word_in = left_word;
            end else if (MY_IDX == cmd.idx) begin
               word_in = cmd.value;
            end
         end
         ile_pkg::CELL_SHIFT_DOWN: begin
            if (MY_IDX >= cmd.idx) begin
               word_in = right_word;
            end
         end
         ile_pkg::CELL_WRITE: begin
            if (MY_IDX == cmd.idx) begin
               word_in = cmd.value;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   // read slice is this word when selected, else zero
   always_comb begin
      rd_in = '0;
      if (cmd.rd_en && (MY_IDX == cmd.rd_idx)) begin
         rd_in = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff <= word_in;
         rd_ff   <= rd_in;
      end
   end

   assign word     = word_ff;
   assign rd_slice = rd_ff;

endmodule

FILE: rtl/ile_ctrl.sv
// request decode, entry count and result register
module ile_ctrl #(
   parameter int DEPTH = ile_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ile_pkg::req_beat_type             req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ile_pkg::rsp_beat_type             rsp_data,
   output ile_pkg::cell_cmd_type             cmd,
   input  logic signed [ile_pkg::WORD_W-1:0] rd_word
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IW    = ile_pkg::CMD_IDX_W;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   busy_ff;
   ile_pkg::status_type    status_ff, status_in;
   logic                   rsp_valid_ff;
   ile_pkg::rsp_beat_type  rsp_data_ff;

   logic             accept;
   logic             advance;
   logic             full;
   logic             empty;
   logic [IW-1:0]    pos_ext;
   logic [IW-1:0]    pos_m1;
   logic [IW-1:0]    cnt_ext;
   logic             pos_bad;
   logic             ins_pos_bad;
   ile_pkg::cell_op_type op;
   logic [IW-1:0]    idx;
   logic             rd_en;

   // handshake: one request in flight, output register decouples the receiver
   assign req_stall = busy_ff;
   assign accept    = req_valid & ~req_stall;
   assign advance   = busy_ff & (~rsp_valid_ff | ~rsp_stall);

   // position checks against the current length
   assign full        = (count_ff >= DEPTH_C);
   assign empty       = (count_ff == '0);
   assign pos_ext     = IW'(req_data.position);
   assign pos_m1      = pos_ext - IW'(1);
   assign cnt_ext     = IW'(count_ff);
   assign pos_bad     = (pos_ext == '0) || (pos_ext > cnt_ext);
   assign ins_pos_bad = (pos_ext == '0) || (pos_ext > (cnt_ext + IW'(1)));

   // decode the action into a cell operation, new length and status
   always_comb begin
      op        = ile_pkg::CELL_HOLD;
      idx       = '0;
      rd_en     = 1'b0;
      count_in  = count_ff;
      status_in = ile_pkg::ST_OK;
      case (req_data.action)
         ile_pkg::ACT_PUSH: begin
            if (full) begin
               status_in = ile_pkg::ST_FULL;
            end else begin
               op       = ile_pkg::CELL_SHIFT_UP;
               count_in = count_ff + CNT_W'(1);
            end
         end
         ile_pkg::ACT_APPEND: begin
            if (full) begin
               status_in = ile_pkg::ST_FULL;
            end else begin
               op       = ile_pkg::CELL_WRITE;
               idx      = cnt_ext;
               count_in = count_ff + CNT_W'(1);
            end
         end
         ile_pkg::ACT_POP: begin
            if (empty) begin
               status_in = ile_pkg::ST_EMPTY;
            end else begin
               op       = ile_pkg::CELL_SHIFT_DOWN;
               rd_en    = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         ile_pkg::ACT_GET: begin
            if (empty) begin
               status_in = ile_pkg::ST_EMPTY;
            end else if (pos_bad) begin
               status_in = ile_pkg::ST_RANGE;
            end else begin
               rd_en = 1'b1;
            end
         end
         ile_pkg::ACT_PUT: begin
            if (empty) begin
               status_in = ile_pkg::ST_EMPTY;
            end else if (pos_bad) begin
               status_in = ile_pkg::ST_RANGE;
            end else begin
               op  = ile_pkg::CELL_WRITE;
               idx = pos_m1;
            end
         end
         ile_pkg::ACT_INSERT: begin
            if (full) begin
               status_in = ile_pkg::ST_FULL;
            end else if (ins_pos_bad) begin
               status_in = ile_pkg::ST_RANGE;
            end else begin
               op       = ile_pkg::CELL_SHIFT_UP;
               idx      = pos_m1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         ile_pkg::ACT_DELETE: begin
            if (empty) begin
               status_in = ile_pkg::ST_EMPTY;
            end else if (pos_bad) begin
               status_in = ile_pkg::ST_RANGE;
            end else begin
               op       = ile_pkg::CELL_SHIFT_DOWN;
               idx      = pos_m1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            count_in = '0;
         end
      endcase
   end

   // broadcast to the cells, only on an accepted beat
   always_comb begin
      cmd.load   = accept;
      cmd.op     = accept ? op : ile_pkg::CELL_HOLD;
      cmd.idx    = idx;
      cmd.rd_en  = accept & rd_en;
      cmd.rd_idx = (req_data.action == ile_pkg::ACT_GET) ? pos_m1 : '0;
      cmd.value  = req_data.value;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (advance) begin
            busy_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (~rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
      end
      if (advance) begin
         rsp_data_ff.read_value <= rd_word;
         rsp_data_ff.count      <= ile_pkg::COUNT_W'(count_ff);
         rsp_data_ff.is_empty   <= (count_ff == '0);
         rsp_data_ff.status     <= status_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // length never goes past the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above depth");

   // a failed request leaves the length alone
   a_err_no_change: assert property (@(posedge clock) disable iff (reset)
      (accept && (status_in != ile_pkg::ST_OK)) |=> (count_ff == $past(count_ff)))
      else $error("length changed on a failed request");

   // an accepted beat is tracked as busy until its result is registered
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("accepted beat not tracked");

   // no second request while one is in flight
   a_single: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !accept)
      else $error("request accepted while busy");

endmodule

FILE: dv/indexed_list_engine_top_tb.sv
// self-checking testbench for the indexed list engine top level
`timescale 1ns / 1ps

module indexed_list_engine_top_tb;

   localparam int LIST_DEPTH    = ile_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_BEATS  = 530;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int HOLD_AFTER    = 150;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 10;
   localparam int REPORT_LIMIT  = 10;

   // word store and length of one copy of the list
   typedef struct {
      logic signed [ile_pkg::WORD_W-1:0] words [LIST_DEPTH];
      int                                len;
   } list_state_type;

   // traffic mix of one random segment
   typedef enum {MIX_GROW, MIX_SHRINK, MIX_BLEND, MIX_NOISE} traffic_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   ile_pkg::req_beat_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   ile_pkg::rsp_beat_type rsp_data;

   ile_pkg::req_beat_type pending_reqs [$];
   ile_pkg::rsp_beat_type expected_rsps [$];
   list_state_type        tracked_list;
   list_state_type        planned_list;

   int  beats_queued = 0;
   int  req_taken = 0;
   int  rsp_seen = 0;
   int  fault_count = 0;
   int  cycle_count = 0;
   bit  req_fire = 1'b0;
   bit  rsp_fire = 1'b0;
   bit  hold_off = 1'b0;
   int  req_gap = 0;
   int  rsp_wait = 0;
   bit  req_calm = 1'b0;
   bit  rsp_calm = 1'b0;

   indexed_list_engine_top #(
      .DEPTH(LIST_DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // apply one request to a list copy and work out its result beat
   task automatic list_step(ref list_state_type s, input ile_pkg::req_beat_type beat,
                            output ile_pkg::rsp_beat_type res);
      int                                pos;
      int                                k;
      logic signed [ile_pkg::WORD_W-1:0] rd;
      ile_pkg::status_type               st;
      bit                                full;
      pos  = int'(beat.position);
      rd   = '0;
      st   = ile_pkg::ST_OK;
      full = s.len >= LIST_DEPTH;
      case (beat.action)
         ile_pkg::ACT_PUSH, ile_pkg::ACT_APPEND: begin
            if (full) begin
               st = ile_pkg::ST_FULL;
            end else if (beat.action == ile_pkg::ACT_PUSH) begin
               for (k = s.len; k > 0; k--) s.words[k] = s.words[k-1];
               s.words[0] = beat.value;
               s.len++;
            end else begin
               s.words[s.len] = beat.value;
               s.len++;
            end
         end
         ile_pkg::ACT_POP: begin
            if (s.len == 0) begin
               st = ile_pkg::ST_EMPTY;
            end else begin
               rd = s.words[0];
               for (k = 0; k + 1 < s.len; k++) s.words[k] = s.words[k+1];
               s.len--;
            end
         end
         ile_pkg::ACT_GET, ile_pkg::ACT_PUT, ile_pkg::ACT_DELETE: begin
            // empty list is reported ahead of a bad position
            if (s.len == 0) begin
               st = ile_pkg::ST_EMPTY;
            end else if (pos == 0 || pos > s.len) begin
               st = ile_pkg::ST_RANGE;
            end else if (beat.action == ile_pkg::ACT_GET) begin
               rd = s.words[pos-1];
            end else if (beat.action == ile_pkg::ACT_PUT) begin
               s.words[pos-1] = beat.value;
            end else begin
               for (k = pos - 1; k + 1 < s.len; k++) s.words[k] = s.words[k+1];
               s.len--;
            end
         end
         ile_pkg::ACT_INSERT: begin
            if (full) begin
               st = ile_pkg::ST_FULL;
            end else if (pos == 0 || pos > s.len + 1) begin
               st = ile_pkg::ST_RANGE;
            end else begin
               for (k = s.len; k > pos - 1; k--) s.words[k] = s.words[k-1];
               s.words[pos-1] = beat.value;
               s.len++;
            end
         end
         default: begin
            s.len = 0;
         end
      endcase
      res.read_value = rd;
      res.count      = ile_pkg::COUNT_W'(s.len);
      res.is_empty   = (s.len == 0);
      res.status     = st;
   endtask

   // add a request to the stimulus and track the length it leaves behind
   task automatic queue_item(input ile_pkg::action_type act, input int pos,
                             input logic [ile_pkg::WORD_W-1:0] val);
      ile_pkg::req_beat_type beat;
      ile_pkg::rsp_beat_type unused;
      beat.action   = act;
      beat.position = ile_pkg::POS_W'(pos);
      beat.value    = val;
      list_step(planned_list, beat, unused);
      pending_reqs.push_back(beat);
      beats_queued++;
   endtask

   // per-beat wait; a calm stretch gives back-to-back beats
   function automatic int draw_wait(ref bit calm);
      if ($urandom_range(0, 31) == 0) calm = !calm;
      return calm ? 0 : int'($urandom_range(0, 15));
   endfunction

   function automatic ile_pkg::action_type pick_action(traffic_type kind);
      int r;
      r = $urandom_range(0, 99);
      case (kind)
         MIX_GROW: begin
            if (r < 30) return ile_pkg::ACT_PUSH;
            if (r < 55) return ile_pkg::ACT_APPEND;
            if (r < 85) return ile_pkg::ACT_INSERT;
            if (r < 92) return ile_pkg::ACT_GET;
            return ile_pkg::ACT_PUT;
         end
         MIX_SHRINK: begin
            if (r < 30) return ile_pkg::ACT_POP;
            if (r < 70) return ile_pkg::ACT_DELETE;
            if (r < 85) return ile_pkg::ACT_GET;
            if (r < 97) return ile_pkg::ACT_PUT;
            return ile_pkg::ACT_CLEAR;
         end
         MIX_BLEND: begin
            if (r < 2) return ile_pkg::ACT_CLEAR;
            return ile_pkg::action_type'($urandom_range(0, 6));
         end
         default: begin
            return ile_pkg::action_type'($urandom_range(0, 7));
         end
      endcase
   endfunction

   // mostly legal positions, with the edges just outside the list mixed in
   function automatic int pick_position(ile_pkg::action_type act, int len);
      int r;
      int top;
      r   = $urandom_range(0, 99);
      top = (act == ile_pkg::ACT_INSERT) ? len + 1 : len;
      if (r < 85 && top >= 1) return $urandom_range(1, top);
      if (r < 92) return top + 1;
      if (r < 95) return 0;
      return $urandom_range(0, 127);
   endfunction

   function automatic logic [ile_pkg::WORD_W-1:0] pick_value();
      case ($urandom_range(0, 39))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // stimulus: directed corners first, then random segments
   initial begin : stimulus
      traffic_type         kind;
      ile_pkg::action_type act;
      int                  seg_len;
      int                  random_count;
      int                  i;
      int                  r;
      planned_list.len = 0;
      tracked_list.len = 0;

      // requests against an empty list
      queue_item(ile_pkg::ACT_POP, 0, 32'h1234_5678);
      queue_item(ile_pkg::ACT_GET, 1, 0);
      queue_item(ile_pkg::ACT_PUT, 1, 32'hdead_beef);
      queue_item(ile_pkg::ACT_DELETE, 1, 0);
      queue_item(ile_pkg::ACT_INSERT, 0, 32'h1);
      queue_item(ile_pkg::ACT_INSERT, 2, 32'h2);
      // build a short list with extreme words
      queue_item(ile_pkg::ACT_INSERT, 1, 32'h8000_0000);
      queue_item(ile_pkg::ACT_PUSH, 0, 32'h7fff_ffff);
      queue_item(ile_pkg::ACT_APPEND, 0, 32'hffff_ffff);
      // position edges around a list of three
      queue_item(ile_pkg::ACT_GET, 0, 0);
      queue_item(ile_pkg::ACT_GET, 4, 0);
      queue_item(ile_pkg::ACT_GET, 127, 0);
      queue_item(ile_pkg::ACT_GET, 1, 0);
      queue_item(ile_pkg::ACT_GET, 3, 0);
      queue_item(ile_pkg::ACT_PUT, 2, 32'h0);
      queue_item(ile_pkg::ACT_GET, 2, 0);
      queue_item(ile_pkg::ACT_DELETE, 0, 0);
      queue_item(ile_pkg::ACT_DELETE, 4, 0);
      queue_item(ile_pkg::ACT_INSERT, 4, 32'h1);
      queue_item(ile_pkg::ACT_INSERT, 6, 32'h2);
      queue_item(ile_pkg::ACT_DELETE, 2, 0);
      queue_item(ile_pkg::ACT_POP, 0, 0);
      queue_item(ile_pkg::ACT_CLEAR, 0, 0);
      queue_item(ile_pkg::ACT_CLEAR, 0, 0);

      // first segment fills the list and keeps pushing into a full one
      kind         = MIX_GROW;
      seg_len      = 100;
      random_count = 0;
      while (random_count < RANDOM_BEATS) begin
         for (i = 0; i < seg_len && random_count < RANDOM_BEATS; i++) begin
            act = pick_action(kind);
            if (kind == MIX_NOISE)
               queue_item(act, $urandom_range(0, 127), $urandom);
            else
               queue_item(act, pick_position(act, planned_list.len), pick_value());
            random_count++;
         end
         r = $urandom_range(0, 9);
         if (r < 3) kind = MIX_GROW;
         else if (r < 6) kind = MIX_SHRINK;
         else if (r < 9) kind = MIX_BLEND;
         else kind = MIX_NOISE;
         seg_len = (kind == MIX_GROW) ? $urandom_range(20, 80) : $urandom_range(10, 40);
      end

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // wait for every beat to be taken and answered, then let the pipe drain
      while (req_taken < beats_queued) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // request driver
   always @(negedge clock) begin : req_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_fire) req_gap = draw_wait(req_calm);
         if (req_valid && !req_fire) begin
            // stalled beat stays as it is
         end else if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (pending_reqs.size() > 0) begin
            req_data  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver with random stalls
   always @(negedge clock) begin : rsp_receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_fire) rsp_wait = draw_wait(rsp_calm);
         if (hold_off) begin
            rsp_stall <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_stall <= 1'b1;
            rsp_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // long receiver hold-off so the block backs up into the request side
   initial begin : hold_window
      while (rsp_seen < HOLD_AFTER) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // beat monitor: predicts on each request beat, checks each result beat
   always @(posedge clock) begin : beat_monitor
      ile_pkg::rsp_beat_type want;
      ile_pkg::rsp_beat_type got;
      req_fire <= !reset && req_valid && !req_stall;
      rsp_fire <= !reset && rsp_valid === 1'b1 && !rsp_stall;
      if (!reset && req_valid && req_stall === 1'b0) begin
         list_step(tracked_list, req_data, want);
         expected_rsps.push_back(want);
         req_taken <= req_taken + 1;
      end
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         got = rsp_data;
         rsp_seen <= rsp_seen + 1;
         if (expected_rsps.size() == 0) begin
            if (fault_count < REPORT_LIMIT)
               $display("result beat %0d arrived with nothing outstanding", rsp_seen);
            fault_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (got.read_value !== want.read_value || got.count !== want.count ||
                got.is_empty !== want.is_empty || got.status !== want.status) begin
               if (fault_count < REPORT_LIMIT) begin
                  $display("result beat %0d mismatch: expected value %0d count %0d",
                           rsp_seen, want.read_value, want.count);
                  $display("  expected empty %0b status %0d, got value %0d count %0d",
                           want.is_empty, want.status, got.read_value, got.count);
                  $display("  got empty %0b status %0d", got.is_empty, got.status);
               end
               fault_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule
